### rtl/xor_rotate_decrypt_pattern_match_defines.svh
// Assertion helpers shared by the RTL. The enclosing module must have clk and arst_n.
`ifndef XOR_ROTATE_DECRYPT_PATTERN_MATCH_DEFINES_SVH
`define XOR_ROTATE_DECRYPT_PATTERN_MATCH_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define XRD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define XRD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/xrd_pkg.sv
package xrd_pkg;

	localparam int PATTERN_MAX = 64;
	localparam int BYTE_W      = 8;
	localparam int ROT_W       = 3;
	localparam int LEN_W       = 7;
	localparam int PIDX_W      = 6;
	localparam int WIDE_W      = LEN_W + 1;
	localparam int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int CNT_W       = $clog2(PATTERN_MAX + 1);
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 8;

	localparam logic [CFG_IDX_W-1:0] REG_XOR_KEY        = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROTATION       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_DATA = 1'b1;

	typedef logic [PATTERN_MAX-1:0][BYTE_W-1:0] pat_arr_t;

	typedef struct packed {
		logic              req_type;
		logic [BYTE_W-1:0] value;
		logic [PIDX_W-1:0] pattern_index;
		logic              last;
	} item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] plain_byte;
		logic              match_here;
		logic              found;
		logic              message_done;
	} res_t;

	typedef struct packed {
		logic              en;
		logic [PIDX_W-1:0] idx;
		logic [BYTE_W-1:0] value;
	} load_t;

	function automatic logic [BYTE_W-1:0] rot_right(input logic [BYTE_W-1:0] b,
		input logic [ROT_W-1:0] r);
		logic [2*BYTE_W-1:0] dbl;
		dbl = {b, b} >> r;
		return dbl[BYTE_W-1:0];
	endfunction

	// 0 acts as 1, anything above PATTERN_MAX acts as PATTERN_MAX
	function automatic logic [CNT_W-1:0] eff_len(input logic [LEN_W-1:0] len);
		logic [WIDE_W-1:0] l;
		l = {1'b0, len};
		if (l == '0)
			l = WIDE_W'(1);
		if (l > WIDE_W'(PATTERN_MAX))
			l = WIDE_W'(PATTERN_MAX);
		return CNT_W'(l);
	endfunction

endpackage

### rtl/xrd_cfg.sv
`include "xor_rotate_decrypt_pattern_match_defines.svh"

module xrd_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_fire,
	input  logic [xrd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [xrd_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  xrd_pkg::load_t                    load,
	output logic [xrd_pkg::BYTE_W-1:0]        xor_key,
	output logic [xrd_pkg::ROT_W-1:0]         rotation,
	output logic [xrd_pkg::CNT_W-1:0]         len_eff,
	output xrd_pkg::pat_arr_t                 apat,
	output logic                              busy
);

	localparam logic [xrd_pkg::IDX_W-1:0] LAST_K = xrd_pkg::IDX_W'(xrd_pkg::PATTERN_MAX - 1);

	logic [xrd_pkg::BYTE_W-1:0] key_q;
	logic [xrd_pkg::ROT_W-1:0]  rot_q;
	logic [xrd_pkg::LEN_W-1:0]  plen_q;

	// pattern as loaded, by index
	logic [xrd_pkg::BYTE_W-1:0] pat_mem [xrd_pkg::PATTERN_MAX];
	// pattern reversed and aligned to the window: apat_q[k] = pattern[len-1-k]
	xrd_pkg::pat_arr_t          apat_q;

	logic                       sweep_q;
	logic [xrd_pkg::IDX_W-1:0]  k_q;
	logic                       wr_pend_s2;
	logic [xrd_pkg::IDX_W-1:0]  wr_k_s2;
	logic [xrd_pkg::BYTE_W-1:0] rd_s2;

	logic [xrd_pkg::IDX_W-1:0]  rd_addr;
	logic [xrd_pkg::WIDE_W-1:0] len_w;
	logic [xrd_pkg::WIDE_W-1:0] lidx_w;
	logic                       mem_ok;
	logic                       apat_hit;
	logic [xrd_pkg::IDX_W-1:0]  apat_pos;
	logic [xrd_pkg::IDX_W-1:0]  mem_pos;
	logic                       len_write;

	assign len_eff   = xrd_pkg::eff_len(plen_q);
	assign len_w     = xrd_pkg::WIDE_W'(len_eff);
	assign lidx_w    = xrd_pkg::WIDE_W'(load.idx);
	assign mem_ok    = lidx_w < xrd_pkg::WIDE_W'(xrd_pkg::PATTERN_MAX);
	assign apat_hit  = lidx_w < len_w;
	assign apat_pos  = xrd_pkg::IDX_W'(len_w - xrd_pkg::WIDE_W'(1) - lidx_w);
	assign mem_pos   = xrd_pkg::IDX_W'(lidx_w);
	assign rd_addr   = xrd_pkg::IDX_W'(len_w - xrd_pkg::WIDE_W'(1) - xrd_pkg::WIDE_W'(k_q));
	assign len_write = cfg_fire && (cfg_index == xrd_pkg::REG_PATTERN_LENGTH);

	assign xor_key  = key_q;
	assign rotation = rot_q;
	assign apat     = apat_q;
	assign busy     = sweep_q || wr_pend_s2;

	always_ff @(posedge clk) begin
		if (load.en && mem_ok)
			pat_mem[mem_pos] <= load.value;
		rd_s2 <= pat_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_pend_s2)
			apat_q[wr_k_s2] <= rd_s2;
		else if (load.en && apat_hit)
			apat_q[apat_pos] <= load.value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q      <= '0;
			rot_q      <= '0;
			plen_q     <= xrd_pkg::LEN_W'(1);
			sweep_q    <= 1'b0;
			k_q        <= '0;
			wr_pend_s2 <= 1'b0;
			wr_k_s2    <= '0;
		end else begin
			if (cfg_fire) begin
				case (cfg_index)
					xrd_pkg::REG_XOR_KEY:        key_q  <= cfg_data[xrd_pkg::BYTE_W-1:0];
					xrd_pkg::REG_ROTATION:       rot_q  <= cfg_data[xrd_pkg::ROT_W-1:0];
					xrd_pkg::REG_PATTERN_LENGTH: plen_q <= cfg_data[xrd_pkg::LEN_W-1:0];
					default: ;
				endcase
			end
			// new length: realign the pattern, one entry a cycle
			if (len_write) begin
				sweep_q <= 1'b1;
				k_q     <= '0;
			end else if (sweep_q) begin
				if (k_q == LAST_K)
					sweep_q <= 1'b0;
				k_q <= k_q + xrd_pkg::IDX_W'(1);
			end
			wr_pend_s2 <= sweep_q && !len_write;
			wr_k_s2    <= k_q;
		end
	end

	`XRD_ASSERT_NEXT(a_len_starts_sweep, len_write, sweep_q && (k_q == '0), "length write did not start realign")
	`XRD_ASSERT_NEXT(a_sweep_ends, sweep_q && (k_q == LAST_K) && !len_write, !sweep_q && wr_pend_s2, "realign did not finish after last entry")
	`XRD_ASSERT_NOW(a_no_load_in_sweep, busy, !load.en, "pattern load during realign")

endmodule

### rtl/xrd_match.sv
module xrd_match (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  xrd_pkg::item_t                item,
	input  logic [xrd_pkg::BYTE_W-1:0]    xor_key,
	input  logic [xrd_pkg::ROT_W-1:0]     rotation,
	input  logic [xrd_pkg::CNT_W-1:0]     len_eff,
	input  xrd_pkg::pat_arr_t             apat,
	output xrd_pkg::res_t                 res
);

	xrd_pkg::pat_arr_t          window_q;
	logic [xrd_pkg::CNT_W-1:0]  seen_q;
	logic                       found_q;

	xrd_pkg::pat_arr_t          win_new;
	logic [xrd_pkg::BYTE_W-1:0] plain;
	logic [xrd_pkg::CNT_W-1:0]  seen_new;
	logic [xrd_pkg::PATTERN_MAX-1:0] pos_ok;
	logic                       is_data;
	logic                       match;
	logic                       found_new;

	assign is_data = item.req_type == xrd_pkg::REQ_DATA;
	assign plain   = xrd_pkg::rot_right(item.value ^ xor_key, rotation);
	assign seen_new = (seen_q < xrd_pkg::CNT_W'(xrd_pkg::PATTERN_MAX)) ?
		seen_q + xrd_pkg::CNT_W'(1) : seen_q;

	always_comb begin
		win_new[0] = plain;
		for (int k = 1; k < xrd_pkg::PATTERN_MAX; k++)
			win_new[k] = window_q[k-1];
	end

	// positions past the pattern length always pass
	always_comb begin
		for (int k = 0; k < xrd_pkg::PATTERN_MAX; k++)
			pos_ok[k] = (xrd_pkg::WIDE_W'(k) >= xrd_pkg::WIDE_W'(len_eff)) ||
				(win_new[k] == apat[k]);
	end

	assign match     = (&pos_ok) && (seen_new >= len_eff);
	assign found_new = found_q || match;

	always_comb begin
		if (is_data) begin
			res.plain_byte   = plain;
			res.match_here   = match;
			res.found        = found_new;
			res.message_done = item.last;
		end else begin
			res = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && is_data)
			window_q <= win_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= '0;
			found_q <= 1'b0;
		end else if (fire && is_data) begin
			seen_q  <= item.last ? '0 : seen_new;
			found_q <= item.last ? 1'b0 : found_new;
		end
	end

endmodule

### rtl/xor_rotate_decrypt_pattern_match.sv
// Channel | Direction | Handshake           | Content
// in      | sink      | in_valid/in_ready   | req_type, value, pattern_index, last
// out     | source    | out_valid/out_ready | plain_byte, match_here, found, message_done
// cfg     | sink      | cfg_valid/cfg_ready | cfg_index, cfg_data (always ready)
//
// One item per cycle unless stalled; path: input register, then result register.
// The window compare of all pattern positions against the shifted window sets the cycle.
// A pattern_length write realigns every stored pattern entry; in is held off until it is done.
// Reset sets length 1, clears other config, counters and found; pattern undefined until loaded.
// A stalled output holds one result and one more item in the input register.
`include "xor_rotate_decrypt_pattern_match_defines.svh"

module xor_rotate_decrypt_pattern_match (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           req_type,
	input  logic [xrd_pkg::BYTE_W-1:0]     value,
	input  logic [xrd_pkg::PIDX_W-1:0]     pattern_index,
	input  logic                           last,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [xrd_pkg::BYTE_W-1:0]     plain_byte,
	output logic                           match_here,
	output logic                           found,
	output logic                           message_done,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [xrd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [xrd_pkg::CFG_DATA_W-1:0] cfg_data
);

	xrd_pkg::item_t             item_s1;
	logic                       valid_s1;
	xrd_pkg::res_t              res_q;
	logic                       out_valid_q;

	xrd_pkg::res_t              res;
	xrd_pkg::load_t             load;
	xrd_pkg::pat_arr_t          apat;
	logic [xrd_pkg::BYTE_W-1:0] xor_key;
	logic [xrd_pkg::ROT_W-1:0]  rotation;
	logic [xrd_pkg::CNT_W-1:0]  len_eff;
	logic                       busy;
	logic                       advance;
	logic                       fire2;
	logic                       in_fire;

	assign advance   = !out_valid_q || out_ready;
	assign fire2     = valid_s1 && advance;
	assign in_ready  = (!valid_s1 || advance) && !busy;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	assign load.en    = fire2 && (item_s1.req_type == xrd_pkg::REQ_LOAD);
	assign load.idx   = item_s1.pattern_index;
	assign load.value = item_s1.value;

	xrd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_fire  (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.load      (load),
		.xor_key   (xor_key),
		.rotation  (rotation),
		.len_eff   (len_eff),
		.apat      (apat),
		.busy      (busy)
	);

	xrd_match u_match (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire2),
		.item     (item_s1),
		.xor_key  (xor_key),
		.rotation (rotation),
		.len_eff  (len_eff),
		.apat     (apat),
		.res      (res)
	);

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.req_type      <= req_type;
			item_s1.value         <= value;
			item_s1.pattern_index <= pattern_index;
			item_s1.last          <= last;
		end
		if (fire2)
			res_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				out_valid_q <= valid_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign plain_byte   = res_q.plain_byte;
	assign match_here   = res_q.match_here;
	assign found        = res_q.found;
	assign message_done = res_q.message_done;

	`XRD_ASSERT_NEXT(a_in_to_s1, in_fire, valid_s1, "accepted item missing from input register")
	`XRD_ASSERT_NEXT(a_s1_holds, valid_s1 && !advance, valid_s1 && $stable(item_s1), "stalled item lost")
	`XRD_ASSERT_NOW(a_match_found, out_valid && match_here, found, "match without found flag")

endmodule

### tb/sv/tb_xor_rotate_decrypt_pattern_match.sv
module tb_xor_rotate_decrypt_pattern_match;
	timeunit 1ns;
	timeprecision 1ps;

	import xrd_pkg::*;

	// index 3 is decoded by nothing; a write there must leave every register alone
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	localparam int N_DIRECTED  = 23;
	localparam int N_PHASES    = 6;
	localparam int PHASE_ITEMS = 210;
	localparam int PRINT_CAP   = 40;

	// per phase: key and rotation of -1 pick a random value
	localparam int PH_KEY [N_PHASES]   = '{-1, 0, 255, -1, -1, -1};
	localparam int PH_ROT [N_PHASES]   = '{0, 7, 3, -1, 5, -1};
	localparam int PH_LEN [N_PHASES]   = '{1, 3, 64, 0, 127, 8};
	localparam int PH_TX [N_PHASES]    = '{0, 85, 0, 22, 0, 22};
	localparam int PH_RX [N_PHASES]    = '{0, 0, 85, 22, 0, 22};
	localparam bit PH_PAUSE [N_PHASES] = '{0, 0, 0, 0, 1, 0};

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

	typedef struct packed {
		row_kind_e             kind;
		logic                  req;
		logic [BYTE_W-1:0]     val;
		logic [PIDX_W-1:0]     idx;
		logic                  lst;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		logic                  typed;
		res_t                  res;
	} step_row_t;

	typedef logic [BYTE_W-1:0] byte_q_t [$];

	localparam step_row_t DIRECTED [N_DIRECTED] = '{
		// key 0, rotation 0, length 1 out of reset
		'{ROW_ITEM, REQ_LOAD, 8'hA5, 6'd0,  1'b0, REG_XOR_KEY, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0}},
		'{ROW_ITEM, REQ_DATA, 8'hA5, 6'd0,  1'b0, REG_XOR_KEY, 8'h00, 1'b1, '{8'hA5, 1'b1, 1'b1, 1'b0}},
		'{ROW_ITEM, REQ_DATA, 8'h00, 6'd0,  1'b1, REG_XOR_KEY, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},
		'{ROW_ITEM, REQ_DATA, 8'hFF, 6'd0,  1'b0, REG_XOR_KEY, 8'h00, 1'b1, '{8'hFF, 1'b0, 1'b0, 1'b0}},
		'{ROW_ITEM, REQ_LOAD, 8'h5A, 6'd63, 1'b0, REG_XOR_KEY, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0}},
		// last on a load must not end the message
		'{ROW_ITEM, REQ_LOAD, 8'hFF, 6'd0,  1'b1, REG_XOR_KEY, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0}},
		'{ROW_ITEM, REQ_DATA, 8'hFF, 6'd0,  1'b1, REG_XOR_KEY, 8'h00, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b1}},
		'{ROW_ITEM, REQ_LOAD, 8'h00, 6'd1,  1'b0, REG_XOR_KEY, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0}},
		'{ROW_CFG,  REQ_LOAD, 8'h00, 6'd0,  1'b0, REG_XOR_KEY, 8'hFF, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0}},
		'{ROW_CFG,  REQ_LOAD, 8'h00, 6'd0,  1'b0, REG_ROTATION, 8'h07, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0}},
		'{ROW_CFG,  REQ_LOAD, 8'h00, 6'd0,  1'b0, REG_PATTERN_LENGTH, 8'h02, 1'b0,
			'{8'h00, 1'b0, 1'b0, 1'b0}},
		// plain FF 00 FF, then a new message whose first byte would complete the window across the boundary
		'{ROW_ITEM, REQ_DATA, 8'h00, 6'd0,  1'b0, REG_XOR_KEY, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0}},
		'{ROW_ITEM, REQ_DATA, 8'hFF, 6'd0,  1'b0, REG_XOR_KEY, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0}},
		'{ROW_ITEM, REQ_DATA, 8'h00, 6'd0,  1'b1, REG_XOR_KEY, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0}},
		'{ROW_ITEM, REQ_DATA, 8'hFF, 6'd0,  1'b0, REG_XOR_KEY, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0}},
		'{ROW_ITEM, REQ_DATA, 8'h00, 6'd0,  1'b0, REG_XOR_KEY, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0}},
		'{ROW_ITEM, REQ_DATA, 8'hFF, 6'd0,  1'b1, REG_XOR_KEY, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0}},
		// zero length behaves as one
		'{ROW_CFG,  REQ_LOAD, 8'h00, 6'd0,  1'b0, REG_PATTERN_LENGTH, 8'h00, 1'b0,
			'{8'h00, 1'b0, 1'b0, 1'b0}},
		'{ROW_ITEM, REQ_DATA, 8'h00, 6'd0,  1'b0, REG_XOR_KEY, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0}},
		'{ROW_CFG,  REQ_LOAD, 8'h00, 6'd0,  1'b0, REG_SPARE, 8'h3C, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0}},
		'{ROW_CFG,  REQ_LOAD, 8'h00, 6'd0,  1'b0, REG_ROTATION, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0}},
		'{ROW_ITEM, REQ_DATA, 8'h3C, 6'd0,  1'b1, REG_XOR_KEY, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0}},
		'{ROW_CFG,  REQ_LOAD, 8'h00, 6'd0,  1'b0, REG_XOR_KEY, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0}}
	};

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  in_valid      = 1'b0;
	logic                  in_ready;
	logic                  req_type      = 1'b0;
	logic [BYTE_W-1:0]     value         = '0;
	logic [PIDX_W-1:0]     pattern_index = '0;
	logic                  last          = 1'b0;
	logic                  out_valid;
	logic                  out_ready     = 1'b0;
	logic [BYTE_W-1:0]     plain_byte;
	logic                  match_here;
	logic                  found;
	logic                  message_done;
	logic                  cfg_valid     = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;

	// predictor state
	logic [BYTE_W-1:0] pat_mem [PATTERN_MAX];
	logic [BYTE_W-1:0] win_mem [PATTERN_MAX];
	int                seen_cnt;
	logic              found_r;
	logic [BYTE_W-1:0] key_r;
	logic [ROT_W-1:0]  rot_r;
	logic [LEN_W-1:0]  len_r;

	res_t expected_results [$];
	res_t head_res;
	int   err_count    = 0;
	int   tx_idle_pct  = 0;
	int   rx_stall_pct = 0;

	xor_rotate_decrypt_pattern_match u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.value        (value),
		.pattern_index(pattern_index),
		.last         (last),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.plain_byte   (plain_byte),
		.match_here   (match_here),
		.found        (found),
		.message_done (message_done),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic logic [BYTE_W-1:0] ror8(input logic [BYTE_W-1:0] b, input int r);
		if (r == 0)
			return b;
		return (b >> r) | (b << (BYTE_W - r));
	endfunction

	function automatic logic [BYTE_W-1:0] rol8(input logic [BYTE_W-1:0] b, input int r);
		if (r == 0)
			return b;
		return (b << r) | (b >> (BYTE_W - r));
	endfunction

	function automatic int span_of(input logic [LEN_W-1:0] l);
		int n;
		n = int'(l);
		if (n == 0)
			n = 1;
		if (n > PATTERN_MAX)
			n = PATTERN_MAX;
		return n;
	endfunction

	function automatic item_t load_item(input logic [PIDX_W-1:0] idx,
		input logic [BYTE_W-1:0] v, input logic lst);
		item_t it;
		it.req_type      = REQ_LOAD;
		it.value         = v;
		it.pattern_index = idx;
		it.last          = lst;
		return it;
	endfunction

	function automatic item_t data_item(input logic [BYTE_W-1:0] v, input logic lst);
		item_t it;
		it.req_type      = REQ_DATA;
		it.value         = v;
		it.pattern_index = PIDX_W'($urandom_range(63));
		it.last          = lst;
		return it;
	endfunction

	// random plain byte, often a pattern byte so partial matches show up
	function automatic logic [BYTE_W-1:0] filler(input int n);
		if ($urandom_range(3) == 0)
			return pat_mem[$urandom_range(n - 1)];
		return BYTE_W'($urandom_range(255));
	endfunction

	task automatic decrypt_and_match(input item_t it, output res_t r);
		int   n;
		logic hit;
		r = '0;
		if (it.req_type == REQ_LOAD) begin
			pat_mem[it.pattern_index] = it.value;
		end else begin
			for (int k = PATTERN_MAX - 1; k > 0; k--)
				win_mem[k] = win_mem[k - 1];
			win_mem[0] = ror8(it.value ^ key_r, int'(rot_r));
			if (seen_cnt < PATTERN_MAX)
				seen_cnt++;
			n   = span_of(len_r);
			hit = (seen_cnt >= n);
			// oldest window byte lines up with pattern byte 0
			if (hit)
				for (int j = 0; j < n; j++)
					if (win_mem[n - 1 - j] != pat_mem[j])
						hit = 1'b0;
			if (hit)
				found_r = 1'b1;
			r.plain_byte   = win_mem[0];
			r.match_here   = hit;
			r.found        = found_r;
			r.message_done = it.last;
			if (it.last) begin
				seen_cnt = 0;
				found_r  = 1'b0;
			end
		end
	endtask

	task automatic report_mismatch(input string what, input logic [BYTE_W-1:0] got,
		input logic [BYTE_W-1:0] want);
		if (err_count < PRINT_CAP)
			$display("%0t ns: %s got %0h want %0h", $realtime, what, got, want);
		err_count++;
	endtask

	task automatic push_item(input item_t it, input logic typed, input res_t typed_res);
		res_t r;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		req_type      <= it.req_type;
		value         <= it.value;
		pattern_index <= it.pattern_index;
		last          <= it.last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		decrypt_and_match(it, r);
		expected_results.push_back(typed ? typed_res : r);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] ri, input logic [CFG_DATA_W-1:0] rv);
		drain_results();
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= ri;
		cfg_data  <= rv;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (ri)
			REG_XOR_KEY:        key_r = rv;
			REG_ROTATION:       rot_r = rv[ROT_W-1:0];
			REG_PATTERN_LENGTH: len_r = rv[LEN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic send_plain(input byte_q_t msg, inout int sent);
		foreach (msg[i])
			push_item(data_item(rol8(msg[i], int'(rot_r)) ^ key_r, i == msg.size() - 1),
				1'b0, '0);
		sent += msg.size();
	endtask

	task automatic run_phase(input int p);
		int      n;
		int      sent;
		int      cut;
		int      pos;
		bit      paused;
		byte_q_t msg;
		tx_idle_pct  = PH_TX[p];
		rx_stall_pct = PH_RX[p];
		write_reg(REG_XOR_KEY, (PH_KEY[p] < 0) ? CFG_DATA_W'($urandom_range(255)) :
			CFG_DATA_W'(PH_KEY[p]));
		write_reg(REG_ROTATION, (PH_ROT[p] < 0) ? CFG_DATA_W'($urandom_range(7)) :
			CFG_DATA_W'(PH_ROT[p]));
		write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(PH_LEN[p]));
		n      = span_of(len_r);
		sent   = 0;
		paused = 0;
		// fresh pattern over the whole compared span before any ciphertext
		for (int k = 0; k < n; k++) begin
			push_item(load_item(PIDX_W'(k), BYTE_W'($urandom_range(255)),
				1'($urandom_range(1))), 1'b0, '0);
			sent++;
		end
		while (sent < PHASE_ITEMS) begin
			if (PH_PAUSE[p] && !paused && sent >= PHASE_ITEMS / 2) begin
				drain_results();
				paused = 1;
			end
			msg = {};
			case ($urandom_range(9))
				0: begin
					// stray load, may rewrite a live pattern byte
					push_item(load_item(PIDX_W'($urandom_range(63)),
						BYTE_W'($urandom_range(255)), 1'($urandom_range(1))), 1'b0, '0);
					sent++;
				end
				1, 2: begin
					repeat ($urandom_range(12, 1)) msg.push_back(filler(n));
					send_plain(msg, sent);
				end
				3: begin
					// pattern split across a message boundary
					cut = $urandom_range(n);
					repeat ($urandom_range(3)) msg.push_back(filler(n));
					for (int k = 0; k < cut; k++)
						msg.push_back(pat_mem[k]);
					if (msg.size() == 0)
						msg.push_back(filler(n));
					send_plain(msg, sent);
					msg = {};
					for (int k = cut; k < n; k++)
						msg.push_back(pat_mem[k]);
					repeat ($urandom_range(3, 1)) msg.push_back(filler(n));
					send_plain(msg, sent);
				end
				default: begin
					repeat ($urandom_range(6)) msg.push_back(filler(n));
					for (int k = 0; k < n; k++)
						msg.push_back(pat_mem[k]);
					if ($urandom_range(4) == 0) begin
						pos      = int'(msg.size()) - 1 - int'($urandom_range(n - 1));
						msg[pos] = msg[pos] ^ BYTE_W'(1 << $urandom_range(7));
					end
					repeat ($urandom_range(4)) msg.push_back(filler(n));
					send_plain(msg, sent);
				end
			endcase
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing expected, plain_byte", plain_byte, '0);
			end else begin
				head_res = expected_results.pop_front();
				if (plain_byte !== head_res.plain_byte)
					report_mismatch("plain_byte", plain_byte, head_res.plain_byte);
				if (match_here !== head_res.match_here)
					report_mismatch("match_here", BYTE_W'(match_here), BYTE_W'(head_res.match_here));
				if (found !== head_res.found)
					report_mismatch("found", BYTE_W'(found), BYTE_W'(head_res.found));
				if (message_done !== head_res.message_done)
					report_mismatch("message_done", BYTE_W'(message_done),
						BYTE_W'(head_res.message_done));
			end
		end
		out_ready <= ($urandom_range(99) >= rx_stall_pct);
	end

	initial begin
		#400_000;
		$display("xor_rotate_decrypt_pattern_match: mismatch");
		$finish;
	end

	initial begin
		item_t it;
		key_r    = '0;
		rot_r    = '0;
		len_r    = LEN_W'(1);
		seen_cnt = 0;
		found_r  = 1'b0;
		for (int k = 0; k < PATTERN_MAX; k++) begin
			pat_mem[k] = '0;
			win_mem[k] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < N_DIRECTED; i++) begin
			if (DIRECTED[i].kind == ROW_CFG) begin
				write_reg(DIRECTED[i].reg_idx, DIRECTED[i].reg_val);
			end else begin
				it.req_type      = DIRECTED[i].req;
				it.value         = DIRECTED[i].val;
				it.pattern_index = DIRECTED[i].idx;
				it.last          = DIRECTED[i].lst;
				push_item(it, DIRECTED[i].typed, DIRECTED[i].res);
			end
		end
		for (int p = 0; p < N_PHASES; p++)
			run_phase(p);
		drain_results();
		repeat (10) @(posedge clk);
		if (err_count == 0)
			$display("xor_rotate_decrypt_pattern_match: match");
		else
			$display("xor_rotate_decrypt_pattern_match: mismatch");
		$finish;
	end

endmodule

### xor_rotate_decrypt_pattern_match.f
+incdir+rtl
rtl/xrd_pkg.sv
rtl/xrd_cfg.sv
rtl/xrd_match.sv
rtl/xor_rotate_decrypt_pattern_match.sv
tb/sv/tb_xor_rotate_decrypt_pattern_match.sv
